FILE: hdl/bodi_pkg.sv
// ----------------------------------------------------------------------------
// Odometry integrator package
// Shared types, register indexes, item kinds, and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package bodi_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_ITERS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int GAIN_Q16      = 39797;

  localparam int VEC_W = 34;
  localparam int ANG_W = 34;
  localparam int CFG_W = 19;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_DAMP_INTERVAL    = 3'd0;
  localparam logic [IDX_W-1:0] REG_PUBLISH_INTERVAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_LINEAR_DECAY     = 3'd2;
  localparam logic [IDX_W-1:0] REG_TURN_DECAY       = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEP_SCALE       = 3'd4;

  localparam logic [2:0] KIND_NAV    = 3'd0;
  localparam logic [2:0] KIND_TEST   = 3'd1;
  localparam logic [2:0] KIND_CLUTCH = 3'd2;
  localparam logic [2:0] KIND_WHEEL  = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  localparam logic [7:0] WHEEL_IGNORE   = 8'd0;
  localparam logic [7:0] WHEEL_SIDEWAYS = 8'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [19:0] speed_turn;
    logic               flag;
    logic [7:0]         wheel_code;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [23:0]        heading;
    logic signed [15:0] out_speed_x;
    logic signed [19:0] out_turn_rate;
  } out_item_t;

  function automatic logic [ANG_W-1:0] atan_turns(input logic [4:0] idx);
    logic [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = 34'd536870912;
      5'd1:    r = 34'd316933406;
      5'd2:    r = 34'd167458907;
      5'd3:    r = 34'd85004756;
      5'd4:    r = 34'd42667331;
      5'd5:    r = 34'd21354465;
      5'd6:    r = 34'd10679838;
      5'd7:    r = 34'd5340245;
      5'd8:    r = 34'd2670163;
      5'd9:    r = 34'd1335087;
      5'd10:   r = 34'd667544;
      5'd11:   r = 34'd333772;
      5'd12:   r = 34'd166886;
      5'd13:   r = 34'd83443;
      5'd14:   r = 34'd41722;
      5'd15:   r = 34'd20861;
      5'd16:   r = 34'd10430;
      5'd17:   r = 34'd5215;
      5'd18:   r = 34'd2608;
      5'd19:   r = 34'd1304;
      5'd20:   r = 34'd652;
      5'd21:   r = 34'd326;
      5'd22:   r = 34'd163;
      5'd23:   r = 34'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bodi_cordic.sv
// ----------------------------------------------------------------------------
// Odometry CORDIC rotator
// Rotates a vector by an angle, one micro-rotation per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bodi_cordic
  import bodi_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [VEC_W-1:0] x_in,
  input  wire logic signed [VEC_W-1:0] y_in,
  input  wire logic signed [ANG_W-1:0] z_in,
  output logic                         done,
  output logic signed [VEC_W-1:0]      x_out,
  output logic signed [VEC_W-1:0]      y_out
);

  logic                    busy;
  logic [4:0]              iter;
  logic signed [VEC_W-1:0] x, y;
  logic signed [ANG_W-1:0] z;
  logic signed [VEC_W-1:0] xs, ys;
  logic signed [ANG_W-1:0] at;

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign at = $signed(atan_turns(iter));
  assign x_out = x;
  assign y_out = y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 5'd1;
        if (iter == 5'(CORDIC_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_in;
      y <= y_in;
      z <= z_in;
    end else if (busy) begin
      if (!z[ANG_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("CORDIC started while busy");
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> iter < 5'(CORDIC_ITERS))
    else $error("CORDIC iteration count out of range");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("CORDIC done while still busy");

endmodule

`default_nettype wire

FILE: hdl/base_odometry_integrator_unit.sv
// ----------------------------------------------------------------------------
// Base odometry integrator
// Dead-reckoning pose of a robot base from velocity commands and ticks.
//
// The input channel takes one item per transfer: velocity commands, clutch
// and wheel settings, and ticks. Non-tick items finish in the cycle of their
// transfer. A tick stalls the input through a setup state, the CORDIC
// rotation at one micro-rotation per cycle, the steps on the shared 34x17
// multiplier for the scale factor, heading step and position products, and
// a closing state. Every tick loads the holding register with the pose from
// before its own step; a publishing tick marks that result pending, and it
// moves to the output register once that is free; the receiver may stall the
// output as long as it wants. A stalled output holds the block at the end of
// the next publishing tick only. The configuration port writes the register
// that cfg_index names. Reset clears the pose and velocity, engages the
// clutch, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module base_odometry_integrator_unit
  import bodi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_ROT  = 5'b00100,
    S_MUL  = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t state;

  logic [7:0]  damp_interval, publish_interval;
  logic [14:0] linear_decay;
  logic [18:0] turn_decay;
  logic [15:0] step_scale;

  logic signed [15:0] vel_x, vel_y;
  logic signed [19:0] vel_turn;
  logic               clutch_on, wheel_sideways;
  logic [39:0]        heading_acc;
  logic signed [31:0] x_acc, y_acc;
  logic [7:0]         damp_phase, publish_phase;

  out_item_t res;
  logic      res_pend;

  logic               in_take;
  logic signed [15:0] dvel_x, dvel_y;
  logic signed [19:0] dvel_turn;

  logic                    cordic_start, cordic_done;
  logic signed [VEC_W-1:0] cx0, cy0, cx, cy;
  logic signed [ANG_W-1:0] cz0;
  logic signed [ANG_W-1:0] zbase;
  logic [31:0]             za;

  logic [2:0]              mstep;
  logic [31:0]             kfac;
  logic signed [VEC_W-1:0] mul_a;
  logic signed [16:0]      mul_b;
  logic signed [50:0]      prod;
  logic signed [66:0]      acc;
  logic signed [66:0]      prod_ext;
  logic signed [31:0]      sat_res;

  function automatic logic signed [20:0] damp_v(input logic signed [20:0] v,
                                                input logic [18:0] d);
    logic signed [20:0] dd;
    dd = $signed({2'b00, d});
    if (v > dd) return v - dd;
    if (v < -dd) return v + dd;
    return '0;
  endfunction

  function automatic logic [7:0] next_phase(input logic [7:0] ph, input logic [7:0] iv);
    logic [8:0] n;
    logic [8:0] ivx;
    ivx = (iv == 8'd0) ? 9'd1 : {1'b0, iv};
    n = {1'b0, ph} + 9'd1;
    return (n >= ivx) ? 8'd0 : n[7:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [26:0] d);
    logic signed [33:0] s;
    s = 34'(a) + 34'(d);
    if (s > 34'sd2147483647) return 32'sh7fffffff;
    if (s < -34'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  assign in_stall = !((state == S_IDLE) && !res_pend);
  assign in_take  = in_valid && !in_stall;

  assign dvel_x    = 16'(damp_v(21'(vel_x), {4'd0, linear_decay}));
  assign dvel_y    = 16'(damp_v(21'(vel_y), {4'd0, linear_decay}));
  assign dvel_turn = 20'(damp_v(21'(vel_turn), turn_decay));

  // Bring the angle into a half turn around zero before rotating.
  assign za    = heading_acc[39:8] - (wheel_sideways ? 32'h40000000 : 32'h0);
  assign zbase = 34'($signed(za));
  always_comb begin
    cx0 = 34'(vel_x) <<< 14;
    cy0 = 34'(vel_y) <<< 14;
    cz0 = zbase;
    if (zbase > 34'sd1073741824) begin
      cx0 = -cx0;
      cy0 = -cy0;
      cz0 = zbase - 34'sd2147483648;
    end else if (zbase < -34'sd1073741824) begin
      cx0 = -cx0;
      cy0 = -cy0;
      cz0 = zbase + 34'sd2147483648;
    end
  end
  assign cordic_start = (state == S_PREP);

  bodi_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (cx0),
    .y_in  (cy0),
    .z_in  (cz0),
    .done  (cordic_done),
    .x_out (cx),
    .y_out (cy)
  );

  always_comb begin
    mul_a = '0;
    mul_b = $signed({1'b0, step_scale});
    case (mstep)
      3'd0: begin
        mul_a = 34'sd39797;
      end
      3'd1: begin
        mul_a = 34'(vel_turn);
      end
      3'd2: begin
        mul_a = cx;
        mul_b = $signed({1'b0, kfac[15:0]});
      end
      3'd3: begin
        mul_a = cx;
        mul_b = $signed({1'b0, kfac[31:16]});
      end
      3'd4: begin
        mul_a = cy;
        mul_b = $signed({1'b0, kfac[15:0]});
      end
      3'd5: begin
        mul_a = cy;
        mul_b = $signed({1'b0, kfac[31:16]});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end
  assign prod     = 51'(mul_a) * 51'(mul_b);
  assign prod_ext = 67'(prod);
  assign sat_res  = sat_add((mstep == 3'd4) ? x_acc : y_acc, acc[66:40]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      damp_interval    <= 8'd10;
      publish_interval <= 8'd5;
      linear_decay     <= 15'd102;
      turn_decay       <= 19'd522;
      step_scale       <= 16'd1311;
      vel_x            <= '0;
      vel_y            <= '0;
      vel_turn         <= '0;
      clutch_on        <= 1'b1;
      wheel_sideways   <= 1'b0;
      heading_acc      <= '0;
      x_acc            <= '0;
      y_acc            <= '0;
      damp_phase       <= '0;
      publish_phase    <= '0;
      res_pend         <= 1'b0;
      out_valid        <= 1'b0;
      mstep            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DAMP_INTERVAL:    damp_interval    <= cfg_data[7:0];
          REG_PUBLISH_INTERVAL: publish_interval <= cfg_data[7:0];
          REG_LINEAR_DECAY:     linear_decay     <= cfg_data[14:0];
          REG_TURN_DECAY:       turn_decay       <= cfg_data[18:0];
          REG_STEP_SCALE:       step_scale       <= cfg_data[15:0];
          default: begin
          end
        endcase
      end

      if (res_pend && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        res_pend  <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_take) begin
            case (in_data.kind)
              KIND_NAV, KIND_TEST: begin
                if (in_data.kind == KIND_TEST || clutch_on) begin
                  vel_x    <= in_data.speed_x;
                  vel_y    <= in_data.speed_y;
                  vel_turn <= in_data.speed_turn;
                end
              end
              KIND_CLUTCH: clutch_on <= in_data.flag;
              KIND_WHEEL: begin
                if (in_data.wheel_code != WHEEL_IGNORE) begin
                  wheel_sideways <= (in_data.wheel_code == WHEEL_SIDEWAYS);
                end
              end
              KIND_TICK: begin
                if (damp_phase == 8'd0) begin
                  vel_x    <= dvel_x;
                  vel_y    <= dvel_y;
                  vel_turn <= dvel_turn;
                end
                if (publish_phase == 8'd0) begin
                  res_pend <= 1'b1;
                end
                damp_phase    <= next_phase(damp_phase, damp_interval);
                publish_phase <= next_phase(publish_phase, publish_interval);
                state         <= S_PREP;
              end
              default: begin
              end
            endcase
          end
        end
        S_PREP: begin
          state <= S_ROT;
        end
        S_ROT: begin
          if (cordic_done) begin
            state <= S_MUL;
            mstep <= '0;
          end
        end
        S_MUL: begin
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd0: kfac <= prod[31:0];
            3'd1: heading_acc <= heading_acc + {prod[31:0], 8'd0};
            3'd2: acc <= prod_ext + (67'sd1 <<< 39);
            3'd3: acc <= acc + (prod_ext <<< 16);
            3'd4: begin
              x_acc <= sat_res;
              acc   <= prod_ext + (67'sd1 <<< 39);
            end
            3'd5: acc <= acc + (prod_ext <<< 16);
            3'd6: begin
              y_acc <= sat_res;
              state <= S_WAIT;
            end
            default: state <= S_WAIT;
          endcase
        end
        S_WAIT: begin
          if (!res_pend) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_data.kind == KIND_TICK) begin
      res.pos_x   <= x_acc;
      res.pos_y   <= y_acc;
      res.heading <= heading_acc[39:16];
      if (damp_phase == 8'd0) begin
        res.out_speed_x   <= dvel_x;
        res.out_turn_rate <= dvel_turn;
      end else begin
        res.out_speed_x   <= vel_x;
        res.out_turn_rate <= vel_turn;
      end
    end
    if (res_pend && (!out_valid || !out_stall)) begin
      out_data <= res;
    end
  end

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    res_pend |-> state != S_IDLE)
    else $error("Pending result while idle");
  a_done_rot: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == S_ROT)
    else $error("Rotation finished outside the rotate state");
  a_tick_prep: assert property (@(posedge clk) disable iff (rst)
    in_take && in_data.kind == KIND_TICK |=> state == S_PREP)
    else $error("Tick transfer did not start the integration");
  a_mul_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> mstep <= 3'd6)
    else $error("Multiply step out of range");

endmodule

`default_nettype wire
